// File: hw/rtl/hdpl_pkg.sv
`default_nettype none

package hdpl_pkg;

    localparam int DEFAULT_INDEX_BITS = 11;
    localparam int VALUE_BITS         = 20;
    localparam int POS_BITS           = 6;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;

    localparam logic [7:0] DIGIT_OFFSET  = 8'h30;
    localparam logic [7:0] CASE_MASK     = 8'hdf;
    localparam logic [7:0] LETTER_OFFSET = 8'h37;

    localparam logic [POS_BITS-1:0] DATA_SKIP = 6'd6;
    localparam logic [POS_BITS-1:0] DATA_LAST = 6'd37;
    localparam logic [POS_BITS-1:0] CFG_SKIP  = 6'd5;
    localparam logic [POS_BITS-1:0] CFG_LAST  = 6'd8;

    localparam logic [VALUE_BITS-1:0] BAD_MARK = 20'h10000;

    localparam logic [1:0] GRP_HI_NIB_LO = 2'd0;
    localparam logic [1:0] GRP_LO_NIB_LO = 2'd1;
    localparam logic [1:0] GRP_HI_NIB_HI = 2'd2;

    localparam logic KIND_PROGRAM = 1'b0;
    localparam logic KIND_CONFIG  = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_COLON = 3'd1,
        PH_SAW1  = 3'd2,
        PH_SAW0  = 3'd3,
        PH_SAW02 = 3'd4,
        PH_DATA  = 3'd5,
        PH_CFG   = 3'd6
    } t_phase;

    function automatic logic [7:0] decode_char(input logic [7:0] c);
        logic [7:0] d;
        d = c;
        if (d inside {[8'h30:8'h39]}) begin
            d = d - DIGIT_OFFSET;
        end
        d = d & CASE_MASK;
        if (d inside {[8'h41:8'h5a]}) begin
            d = d - LETTER_OFFSET;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hdpl_text_if.sv
`default_nettype none

interface hdpl_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hdpl_word_if.sv
`default_nettype none

interface hdpl_word_if #(
    parameter int INDEX_BITS = hdpl_pkg::DEFAULT_INDEX_BITS
);
    logic                                valid;
    logic                                ready;
    logic                                word_kind;
    logic [INDEX_BITS-1:0]               word_index;
    logic [hdpl_pkg::VALUE_BITS-1:0]     word_value;

    modport source (output valid, output word_kind, output word_index, output word_value,
                    input ready);
    modport sink   (input valid, input word_kind, input word_index, input word_value,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hex_dump_program_loader.sv
`default_nettype none

// Hex-dump program loader: takes one text character per transfer on i_text and emits
// program words (from ':10' data records) and one config word (from a ':021' record)
// on o_word. One character is accepted every cycle unless o_word stalls with the input
// and result registers full; a character passes the input register and then the parse
// state and the result register, which drives o_word.
// The input register and the result register each hold while o_word stalls, so
// input keeps flowing until both are full.
// After the config word the parser ignores text until a character marked
// end_of_text, which returns the parse state to its reset values.
module hex_dump_program_loader #(
    parameter int INDEX_BITS = hdpl_pkg::DEFAULT_INDEX_BITS
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    hdpl_text_if.sink      i_text,
    hdpl_word_if.source    o_word
);
    import hdpl_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // parse state
    t_phase                  r_phase, n_phase;
    logic [POS_BITS-1:0]     r_pos, n_pos;
    logic [VALUE_BITS-1:0]   r_partial, n_partial;
    logic [INDEX_BITS-1:0]   r_index, n_index;
    logic                    r_slot, n_slot;
    logic                    r_done, n_done;

    // result register
    logic                    r_out_valid;
    logic                    r_kind, n_kind;
    logic [INDEX_BITS-1:0]   r_out_index, n_out_index;
    logic [VALUE_BITS-1:0]   r_value, n_value;
    logic                    n_emit;

    logic       advance;
    logic [7:0] dec;
    logic       dec_ok;
    logic [1:0] grp;

    assign advance      = r_in_valid && (!r_out_valid || o_word.ready);
    assign i_text.ready = !r_in_valid || advance;

    assign o_word.valid      = r_out_valid;
    assign o_word.word_kind  = r_kind;
    assign o_word.word_index = r_out_index;
    assign o_word.word_value = r_value;

    assign dec    = decode_char(r_in_byte);
    assign dec_ok = (dec[7:4] == 4'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
        if (i_text.valid && i_text.ready) begin
            r_in_byte <= i_text.text_byte;
            r_in_last <= i_text.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_pos     <= '0;
            r_partial <= '0;
            r_index   <= '0;
            r_slot    <= 1'b0;
            r_done    <= 1'b0;
        end else if (advance) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_partial <= n_partial;
            r_index   <= n_index;
            r_slot    <= n_slot;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_emit;
        end else if (o_word.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && n_emit) begin
            r_kind      <= n_kind;
            r_out_index <= n_out_index;
            r_value     <= n_value;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_partial   = r_partial;
        n_index     = r_index;
        n_slot      = r_slot;
        n_done      = r_done;
        n_emit      = 1'b0;
        n_kind      = KIND_PROGRAM;
        n_out_index = r_index;
        n_value     = '0;
        grp         = 2'(r_pos - DATA_SKIP);

        if (!r_done) begin
            case (r_phase)
                PH_COLON: begin
                    if (r_in_byte == CH_ZERO) begin
                        n_phase = PH_SAW0;
                    end else if (r_in_byte == CH_ONE && !r_slot) begin
                        n_phase = PH_SAW1;
                    end else if (r_in_byte == CH_COLON) begin
                        n_phase = PH_COLON;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                    n_slot = 1'b0;
                end
                PH_SAW1: begin
                    if (r_in_byte == CH_ZERO) begin
                        n_phase = PH_DATA;
                        n_pos   = '0;
                    end else begin
                        n_phase = (r_in_byte == CH_COLON) ? PH_COLON : PH_HUNT;
                    end
                end
                PH_SAW0: begin
                    if (r_in_byte == CH_TWO) begin
                        n_phase = PH_SAW02;
                    end else begin
                        n_phase = (r_in_byte == CH_COLON) ? PH_COLON : PH_HUNT;
                    end
                end
                PH_SAW02: begin
                    if (r_in_byte == CH_ONE) begin
                        n_phase = PH_CFG;
                        n_pos   = '0;
                    end else begin
                        n_phase = (r_in_byte == CH_COLON) ? PH_COLON : PH_HUNT;
                    end
                end
                PH_DATA: begin
                    if (r_pos >= DATA_SKIP) begin
                        if (grp == GRP_HI_NIB_LO) begin
                            n_partial = dec_ok ? {12'd0, dec[3:0], 4'd0} : BAD_MARK;
                        end else if (!dec_ok) begin
                            n_partial = r_partial | BAD_MARK;
                        end else if (grp == GRP_LO_NIB_LO) begin
                            n_partial = r_partial | {12'd0, dec};
                        end else if (grp == GRP_HI_NIB_HI) begin
                            n_partial = r_partial | {dec, 12'd0};
                        end else if ((r_partial & BAD_MARK) == '0) begin
                            n_emit      = 1'b1;
                            n_kind      = KIND_PROGRAM;
                            n_out_index = r_index;
                            n_value     = {4'd0, r_partial[15:0] | {dec, 8'd0}};
                            n_index     = r_index + 1'b1;
                        end
                    end
                    if (r_pos >= DATA_LAST) begin
                        n_phase = PH_HUNT;
                        n_pos   = '0;
                        n_slot  = 1'b1;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                PH_CFG: begin
                    if (r_pos >= CFG_SKIP) begin
                        case (2'(r_pos - CFG_SKIP))
                            GRP_HI_NIB_LO: n_partial = {8'd0, dec, 4'd0};
                            GRP_LO_NIB_LO: n_partial = r_partial | {12'd0, dec};
                            GRP_HI_NIB_HI: n_partial = r_partial | {dec, 12'd0};
                            default: begin
                                n_emit      = 1'b1;
                                n_kind      = KIND_CONFIG;
                                n_out_index = '0;
                                n_value     = r_partial | {4'd0, dec, 8'd0};
                                n_done      = 1'b1;
                                n_phase     = PH_HUNT;
                            end
                        endcase
                    end
                    n_pos = (r_pos < CFG_LAST) ? r_pos + 1'b1 : '0;
                end
                default: begin
                    if (r_in_byte == CH_COLON) begin
                        n_phase = PH_COLON;
                    end else begin
                        n_phase = PH_HUNT;
                        n_slot  = 1'b0;
                    end
                end
            endcase
        end

        if (r_in_last) begin
            n_phase   = PH_HUNT;
            n_pos     = '0;
            n_partial = '0;
            n_index   = '0;
            n_slot    = 1'b0;
            n_done    = 1'b0;
        end
    end

endmodule

`default_nettype wire
